// ----- hw/rtl/jtl_pkg.sv -----
`default_nettype none

package jtl_pkg;

  localparam int unsigned NUMBER_BITS = 64;
  localparam int unsigned NUM_OUT_W   = 64;
  localparam int unsigned ACC_EXT_W   = NUMBER_BITS + 4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // token kinds
  localparam logic [4:0] KIND_LBRACE     = 5'd0;
  localparam logic [4:0] KIND_RBRACE     = 5'd1;
  localparam logic [4:0] KIND_LBRACKET   = 5'd2;
  localparam logic [4:0] KIND_RBRACKET   = 5'd3;
  localparam logic [4:0] KIND_COLON      = 5'd4;
  localparam logic [4:0] KIND_COMMA      = 5'd5;
  localparam logic [4:0] KIND_STR_CHAR   = 5'd6;
  localparam logic [4:0] KIND_STR_END    = 5'd7;
  localparam logic [4:0] KIND_NUMBER     = 5'd8;
  localparam logic [4:0] KIND_TRUE       = 5'd9;
  localparam logic [4:0] KIND_FALSE      = 5'd10;
  localparam logic [4:0] KIND_NULL       = 5'd11;
  localparam logic [4:0] KIND_END        = 5'd12;
  localparam logic [4:0] KIND_ERR_WORD   = 5'd13;
  localparam logic [4:0] KIND_ERR_BYTE   = 5'd14;
  localparam logic [4:0] KIND_ERR_STRING = 5'd15;
  localparam logic [4:0] KIND_ERR_MINUS  = 5'd16;

  // characters
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam logic [2:0] CAND_ALL = 3'b111;
  localparam logic [2:0] POS_MAX  = 3'd7;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_STRING = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_WORD   = 5'b01000,
    MODE_HALTED = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [4:0]           kind;
    logic [7:0]           ch;
    logic [NUM_OUT_W-1:0] num;
    logic                 last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd4;
      2'd1:    r = 3'd5;
      2'd2:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // drop every keyword candidate that does not have c at position pos
  function automatic logic [2:0] kw_filter(input logic [2:0] cand, input logic [2:0] pos,
                                           input logic [7:0] c);
    logic [2:0] r;
    r = cand;
    for (int k = 0; k < 3; k++) begin
      if (!(pos < kw_len(2'(k)) && kw_char(2'(k), pos) == c)) r[k] = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jtl_core.sv -----
`default_nettype none

module jtl_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          eoi_i,
  output jtl_pkg::push_t     push_o
);

  localparam int unsigned NB = jtl_pkg::NUMBER_BITS;
  localparam int unsigned XW = jtl_pkg::ACC_EXT_W;
  localparam logic [NB-1:0] LIM     = NB'(1) << (NB - 1);
  localparam logic [XW-1:0] LIM_EXT = XW'(LIM);

  jtl_pkg::mode_e  mode_q, mode_d;
  logic [NB-1:0]   acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            seen_q, seen_d;
  logic [2:0]      cand_q, cand_d;
  logic [2:0]      pos_q, pos_d;

  logic            is_ws, is_digit, is_letter;
  logic [7:0]      digit_val;
  logic [XW-1:0]   acc_ext, acc_mul;
  logic [NB-1:0]   acc_neg;
  logic [NB-1:0]   acc_pos;
  logic [2:0]      pos_inc;

  // outcome of lexing the byte as the start of a new token
  logic            idle_v;
  jtl_pkg::tok_t   idle_tok;
  jtl_pkg::mode_e  idle_mode;

  logic            first_v, run_idle;
  jtl_pkg::tok_t   first_tok;

  assign is_ws     = (byte_i == jtl_pkg::CH_SPACE) ||
                     (byte_i >= jtl_pkg::CH_TAB && byte_i <= jtl_pkg::CH_CR);
  assign is_digit  = (byte_i >= jtl_pkg::CH_ZERO) && (byte_i <= jtl_pkg::CH_NINE);
  assign is_letter = (byte_i >= "a" && byte_i <= "z") || (byte_i >= "A" && byte_i <= "Z");
  assign digit_val = byte_i - jtl_pkg::CH_ZERO;

  // acc * 10 + digit, as two shifts and adds
  assign acc_ext = XW'(acc_q);
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + XW'(digit_val[3:0]);
  assign acc_neg = NB'(0) - acc_q;
  assign acc_pos = (acc_q >= LIM) ? LIM - NB'(1) : acc_q;
  assign pos_inc = (pos_q < jtl_pkg::POS_MAX) ? pos_q + 3'd1 : pos_q;

  always_comb begin
    idle_v    = 1'b0;
    idle_tok  = '0;
    idle_mode = jtl_pkg::MODE_IDLE;
    if (eoi_i) begin
      idle_v        = 1'b1;
      idle_tok.kind = jtl_pkg::KIND_END;
    end else if (is_ws) begin
      idle_v = 1'b0;
    end else if (byte_i == jtl_pkg::CH_QUOTE) begin
      idle_mode = jtl_pkg::MODE_STRING;
    end else if (is_digit || byte_i == jtl_pkg::CH_MINUS) begin
      idle_mode = jtl_pkg::MODE_NUMBER;
    end else if (is_letter) begin
      idle_mode = jtl_pkg::MODE_WORD;
    end else begin
      idle_v = 1'b1;
      case (byte_i)
        jtl_pkg::CH_LBRACE:   idle_tok.kind = jtl_pkg::KIND_LBRACE;
        jtl_pkg::CH_RBRACE:   idle_tok.kind = jtl_pkg::KIND_RBRACE;
        jtl_pkg::CH_LBRACKET: idle_tok.kind = jtl_pkg::KIND_LBRACKET;
        jtl_pkg::CH_RBRACKET: idle_tok.kind = jtl_pkg::KIND_RBRACKET;
        jtl_pkg::CH_COLON:    idle_tok.kind = jtl_pkg::KIND_COLON;
        jtl_pkg::CH_COMMA:    idle_tok.kind = jtl_pkg::KIND_COMMA;
        default: begin
          idle_tok.kind = jtl_pkg::KIND_ERR_BYTE;
          idle_mode     = jtl_pkg::MODE_HALTED;
        end
      endcase
      if (idle_mode != jtl_pkg::MODE_HALTED) idle_tok.ch = byte_i;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    cand_d    = cand_q;
    pos_d     = pos_q;
    first_v   = 1'b0;
    first_tok = '0;
    run_idle  = 1'b0;

    unique case (mode_q)
      jtl_pkg::MODE_HALTED: begin
        mode_d = jtl_pkg::MODE_HALTED;
      end
      jtl_pkg::MODE_STRING: begin
        first_v = 1'b1;
        if (eoi_i) begin
          first_tok.kind = jtl_pkg::KIND_ERR_STRING;
          mode_d         = jtl_pkg::MODE_HALTED;
        end else if (byte_i == jtl_pkg::CH_QUOTE) begin
          first_tok.kind = jtl_pkg::KIND_STR_END;
          mode_d         = jtl_pkg::MODE_IDLE;
        end else begin
          first_tok.kind = jtl_pkg::KIND_STR_CHAR;
          first_tok.ch   = byte_i;
        end
      end
      jtl_pkg::MODE_NUMBER: begin
        if (!eoi_i && is_digit) begin
          acc_d  = (acc_mul > LIM_EXT) ? LIM : acc_mul[NB-1:0];
          seen_d = 1'b1;
        end else if (!seen_q) begin
          // minus sign with no digit; the closing byte is dropped
          first_v        = 1'b1;
          first_tok.kind = jtl_pkg::KIND_ERR_MINUS;
          mode_d         = jtl_pkg::MODE_HALTED;
        end else begin
          first_v        = 1'b1;
          first_tok.kind = jtl_pkg::KIND_NUMBER;
          first_tok.num  = neg_q ? jtl_pkg::NUM_OUT_W'(signed'(acc_neg))
                                 : jtl_pkg::NUM_OUT_W'(acc_pos);
          run_idle       = 1'b1;
        end
      end
      jtl_pkg::MODE_WORD: begin
        if (!eoi_i && is_letter) begin
          cand_d = jtl_pkg::kw_filter(cand_q, pos_q, byte_i);
          pos_d  = pos_inc;
        end else begin
          first_v  = 1'b1;
          run_idle = 1'b1;
          if (cand_q[0] && pos_q == jtl_pkg::kw_len(2'd0)) begin
            first_tok.kind = jtl_pkg::KIND_TRUE;
          end else if (cand_q[1] && pos_q == jtl_pkg::kw_len(2'd1)) begin
            first_tok.kind = jtl_pkg::KIND_FALSE;
          end else if (cand_q[2] && pos_q == jtl_pkg::kw_len(2'd2)) begin
            first_tok.kind = jtl_pkg::KIND_NULL;
          end else begin
            first_tok.kind = jtl_pkg::KIND_ERR_WORD;
            mode_d         = jtl_pkg::MODE_HALTED;
            run_idle       = 1'b0;
          end
        end
      end
      jtl_pkg::MODE_IDLE: begin
        run_idle = 1'b1;
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_d = idle_mode;
      if (idle_mode == jtl_pkg::MODE_NUMBER) begin
        neg_d  = (byte_i == jtl_pkg::CH_MINUS);
        seen_d = (byte_i != jtl_pkg::CH_MINUS);
        acc_d  = (byte_i == jtl_pkg::CH_MINUS) ? '0 : NB'(digit_val[3:0]);
      end
      if (idle_mode == jtl_pkg::MODE_WORD) begin
        cand_d = jtl_pkg::kw_filter(jtl_pkg::CAND_ALL, 3'd0, byte_i);
        pos_d  = 3'd1;
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (fire_i) begin
      if (first_v && run_idle && idle_v) begin
        push_o.count     = 2'd2;
        push_o.tok0      = first_tok;
        push_o.tok1      = idle_tok;
        push_o.tok1.last = 1'b1;
      end else if (first_v) begin
        push_o.count     = 2'd1;
        push_o.tok0      = first_tok;
        push_o.tok0.last = 1'b1;
      end else if (run_idle && idle_v) begin
        push_o.count     = 2'd1;
        push_o.tok0      = idle_tok;
        push_o.tok0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jtl_pkg::MODE_IDLE;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      seen_q <= 1'b0;
      cand_q <= jtl_pkg::CAND_ALL;
      pos_q  <= 3'd0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      seen_q <= seen_d;
      cand_q <= cand_d;
      pos_q  <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jtl_queue.sv -----
`default_nettype none

module jtl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jtl_pkg::push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output jtl_pkg::tok_t      tok_o
);

  localparam int unsigned PW = jtl_pkg::QPTR_W;
  localparam int unsigned CW = jtl_pkg::QCNT_W;

  jtl_pkg::tok_t mem_q [jtl_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  // two free entries are needed, since one transaction can leave two tokens
  assign room_o  = cnt_q <= CW'(jtl_pkg::QUEUE_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + PW'(1)] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      cnt_q <= cnt_q + CW'(push_i.count) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/json_token_lexer.sv -----
// Byte-serial JSON lexer. Each input transaction carries one byte or an
// end-of-input mark and is lexed in the cycle it is accepted; its tokens
// (zero, one or two) enter a four-entry result queue and appear on the output
// from the next cycle on, one per cycle. A byte is taken every cycle while the
// queue has two free entries, so a stream runs at one byte per clock as long
// as the sink takes one token per cycle; a byte that both closes a number or
// word and opens punctuation or end-of-input yields two tokens, and the
// queue's single read port then sets the pace at one token per cycle.
// last_of_run_o marks the final token of each input transaction. After an
// error token the lexer still accepts bytes but yields nothing until reset.
`default_nettype none

module json_token_lexer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         byte_in_i,
  input  wire logic               end_of_input_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              token_kind_o,
  output logic [7:0]              char_value_o,
  output logic signed [63:0]      number_value_o,
  output logic                    last_of_run_o
);

  jtl_pkg::push_t push;
  jtl_pkg::tok_t  tok;
  logic           room;
  logic           fire;

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  jtl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_in_i),
    .eoi_i  (end_of_input_i),
    .push_o (push)
  );

  jtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .tok_o   (tok)
  );

  assign token_kind_o   = tok.kind;
  assign char_value_o   = tok.ch;
  assign number_value_o = signed'(tok.num);
  assign last_of_run_o  = tok.last;

endmodule

`default_nettype wire

// ----- hw/rtl/jtl_checker.sv -----
`default_nettype none

module jtl_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [7:0]         byte_in_i,
  input wire logic               end_of_input_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [4:0]         token_kind_o,
  input wire logic [7:0]         char_value_o,
  input wire logic signed [63:0] number_value_o,
  input wire logic               last_of_run_o
);

  // a stalled token stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(char_value_o) && $stable(number_value_o) && $stable(last_of_run_o))
    else $error("output token changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= jtl_pkg::KIND_ERR_MINUS)
    else $error("token kind out of range");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o > jtl_pkg::KIND_STR_CHAR |-> char_value_o == 8'h00)
    else $error("char value set on a non-character token");

  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != jtl_pkg::KIND_NUMBER |-> number_value_o == '0)
    else $error("number value set on a non-number token");

  // an error token ends the run of its transaction
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o >= jtl_pkg::KIND_ERR_WORD |-> last_of_run_o)
    else $error("error token not last of its run");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (.*);

`default_nettype wire
